FILE: hw/rtl/sequence_gap_resend_tracker_defines.svh
// Assertion macros shared by the sequence gap tracker RTL.
`ifndef SEQUENCE_GAP_RESEND_TRACKER_DEFINES_SVH
`define SEQUENCE_GAP_RESEND_TRACKER_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define SGRT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside of reset.
`define SGRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/sgrt_pkg.sv
// Types and constants for the sequence gap resend tracker.
package sgrt_pkg;

   // Number of sequence slots; valid numbers are 1 to SEQ_SLOTS - 1.
   localparam int SEQ_SLOTS = 64;
   // Width of a packet id on the result channel.
   localparam int ID_W      = 6;
   // Depth of the received bitmap, covering every id value.
   localparam int MAP_DEPTH = 2 ** ID_W;
   // Distinct count width, wide enough to hold MAP_DEPTH.
   localparam int CNT_W     = ID_W + 1;
   localparam int SEQ_W     = 32;

   // Input command codes.
   localparam logic CMD_PACKET  = 1'b0;
   localparam logic CMD_CONNECT = 1'b1;

   // Request type codes on the result channel.
   typedef enum logic [1:0] {
      REQ_NONE   = 2'd0,
      REQ_FULL   = 2'd1,
      REQ_RESEND = 2'd2
   } req_kind_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

endpackage

FILE: hw/rtl/sgrt_if.sv
// Valid/ready channel interfaces for the tracker's input and result items.
interface sgrt_req_if;
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [sgrt_pkg::SEQ_W-1:0] sequence_req;

   modport source (output valid, output cmd, output sequence_req, input ready);
   modport sink   (input valid, input cmd, input sequence_req, output ready);
endinterface

interface sgrt_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                request_type;
   logic [sgrt_pkg::ID_W-1:0] packet_id;
   logic                      last;
   logic                      complete;
   logic                      seq_out_of_range;

   modport source (output valid, output request_type, output packet_id, output last,
                   output complete, output seq_out_of_range, input ready);
   modport sink   (input valid, input request_type, input packet_id, input last,
                   input complete, input seq_out_of_range, output ready);
endinterface

FILE: hw/rtl/sequence_gap_resend_tracker.sv
// Sequence gap tracker top level: bitmap, counters, gap scan sequencer.
//
// Usage: packet items (cmd = 0) carry a sequence number on the req channel.
// The block marks the number in a 64-slot bitmap and updates the highest
// number and the distinct count; numbers of 0 or at or above the slot count
// are flagged with seq_out_of_range and leave the state alone. Every packet
// item gives one status item on the rsp channel the cycle after it is taken.
// A connect item (cmd = 1) asks for the full stream when nothing has been
// stored; otherwise a sequencer walks the bitmap from 1 to the highest
// number, one slot per cycle through a single index compare while no gap
// waits on the result register, and sends one resend item per missing
// number, or one no-request item if there is no gap. The final item of each
// answer has last set. Packet items can be taken back to back while the
// result register frees up; req.ready is low for the whole scan. The result
// register holds one item, so the next input item is taken while a finished
// item waits, provided the register frees up. When the receiver stalls, the
// result register holds and the scan waits once it has a gap to send.
// Reset (synchronous) clears the bitmap, the counters and the channels.
`include "sequence_gap_resend_tracker_defines.svh"

module sequence_gap_resend_tracker (
   input  logic        clock,
   input  logic        reset,
   sgrt_req_if.sink    req,
   sgrt_rsp_if.source  rsp
);

   sgrt_pkg::state_type state_ff, state_in;

   logic [sgrt_pkg::MAP_DEPTH-1:0] map_ff, map_in;
   logic [sgrt_pkg::ID_W-1:0]      highest_ff, highest_in;
   logic [sgrt_pkg::CNT_W-1:0]     count_ff, count_in;

   // Scan index runs one past the highest number, so it carries an extra bit.
   logic [sgrt_pkg::ID_W:0]        idx_ff, idx_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [sgrt_pkg::ID_W-1:0]      pend_id_ff, pend_id_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   sgrt_pkg::req_kind_type         rsp_type_ff, rsp_type_in;
   logic [sgrt_pkg::ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           rsp_complete_ff, rsp_complete_in;
   logic                           rsp_oor_ff, rsp_oor_in;

   logic                           out_free;
   logic                           accept;
   logic                           scan_done;
   logic                           slot_missing;
   logic                           seq_ok;
   logic [sgrt_pkg::ID_W-1:0]      seq_idx;

   // Handshake and shared scan compare.
   assign out_free     = !rsp_valid_ff || rsp.ready;
   assign req.ready    = (state_ff == sgrt_pkg::ST_IDLE) && out_free;
   assign accept       = req.valid && req.ready;
   assign scan_done    = idx_ff > {1'b0, highest_ff};
   assign slot_missing = !map_ff[idx_ff[sgrt_pkg::ID_W-1:0]];
   assign seq_ok       = (req.sequence_req != '0) &&
                         (req.sequence_req < sgrt_pkg::SEQ_W'(sgrt_pkg::SEQ_SLOTS));
   assign seq_idx      = req.sequence_req[sgrt_pkg::ID_W-1:0];

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sgrt_pkg::ST_IDLE: begin
            if (accept && (req.cmd == sgrt_pkg::CMD_CONNECT) && (count_ff != '0)) begin
               state_in = sgrt_pkg::ST_SCAN;
            end
         end
         sgrt_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = sgrt_pkg::ST_FLUSH;
            end
         end
         sgrt_pkg::ST_FLUSH: begin
            if (out_free) begin
               state_in = sgrt_pkg::ST_IDLE;
            end
         end
         default: state_in = sgrt_pkg::ST_IDLE;
      endcase
   end

   // Datapath and result register updates.
   always_comb begin
      logic emit;
      emit            = 1'b0;
      map_in          = map_ff;
      highest_in      = highest_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      pend_valid_in   = pend_valid_ff;
      pend_id_in      = pend_id_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_type_in     = rsp_type_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_oor_in      = rsp_oor_ff;
      rsp_complete_in = rsp_complete_ff;

      unique case (state_ff)
         sgrt_pkg::ST_IDLE: begin
            if (accept) begin
               if (req.cmd == sgrt_pkg::CMD_PACKET) begin
                  // Mark the slot, count it once, track the highest number.
                  if (seq_ok) begin
                     if (!map_ff[seq_idx]) begin
                        map_in[seq_idx] = 1'b1;
                        count_in        = count_ff + 1'b1;
                     end
                     if (seq_idx > highest_ff) begin
                        highest_in = seq_idx;
                     end
                  end
                  emit        = 1'b1;
                  rsp_type_in = sgrt_pkg::REQ_NONE;
                  rsp_id_in   = '0;
                  rsp_last_in = 1'b1;
                  rsp_oor_in  = !seq_ok;
               end else if (count_ff == '0) begin
                  emit        = 1'b1;
                  rsp_type_in = sgrt_pkg::REQ_FULL;
                  rsp_id_in   = '0;
                  rsp_last_in = 1'b1;
                  rsp_oor_in  = 1'b0;
               end else begin
                  idx_in        = (sgrt_pkg::ID_W+1)'(1);
                  pend_valid_in = 1'b0;
               end
            end
         end
         sgrt_pkg::ST_SCAN: begin
            // A found gap is held back until the next one is found so the final one can carry last.
            if (!scan_done) begin
               if (slot_missing) begin
                  if (!pend_valid_ff) begin
                     pend_valid_in = 1'b1;
                     pend_id_in    = idx_ff[sgrt_pkg::ID_W-1:0];
                     idx_in        = idx_ff + 1'b1;
                  end else if (out_free) begin
                     emit        = 1'b1;
                     rsp_type_in = sgrt_pkg::REQ_RESEND;
                     rsp_id_in   = pend_id_ff;
                     rsp_last_in = 1'b0;
                     rsp_oor_in  = 1'b0;
                     pend_id_in  = idx_ff[sgrt_pkg::ID_W-1:0];
                     idx_in      = idx_ff + 1'b1;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         sgrt_pkg::ST_FLUSH: begin
            // Send the held gap as the last item, or a no-request item.
            if (out_free) begin
               emit          = 1'b1;
               rsp_type_in   = pend_valid_ff ? sgrt_pkg::REQ_RESEND : sgrt_pkg::REQ_NONE;
               rsp_id_in     = pend_valid_ff ? pend_id_ff : '0;
               rsp_last_in   = 1'b1;
               rsp_oor_in    = 1'b0;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      if (emit) begin
         rsp_valid_in    = 1'b1;
         rsp_complete_in = (highest_in != '0) &&
                           (count_in == sgrt_pkg::CNT_W'(highest_in));
      end
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sgrt_pkg::ST_IDLE;
         map_ff        <= '0;
         highest_ff    <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         map_ff        <= map_in;
         highest_ff    <= highest_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      pend_id_ff      <= pend_id_in;
      rsp_type_ff     <= rsp_type_in;
      rsp_id_ff       <= rsp_id_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_complete_ff <= rsp_complete_in;
      rsp_oor_ff      <= rsp_oor_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.request_type     = rsp_type_ff;
   assign rsp.packet_id        = rsp_id_ff;
   assign rsp.last             = rsp_last_ff;
   assign rsp.complete         = rsp_complete_ff;
   assign rsp.seq_out_of_range = rsp_oor_ff;

   // Checks on the sequencer and the counters.
   `SGRT_ASSERT_NOW(a_busy_not_ready, state_ff != sgrt_pkg::ST_IDLE, !req.ready, "ready while scanning")
   `SGRT_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= sgrt_pkg::CNT_W'(highest_ff), "count above highest")
   `SGRT_ASSERT_NOW(a_resend_id, rsp_valid_ff && (rsp_type_ff == sgrt_pkg::REQ_RESEND), (rsp_id_ff != '0) && (rsp_id_ff < highest_ff) && !map_ff[rsp_id_ff], "bad resend id")
   `SGRT_ASSERT_NOW(a_oor_form, rsp_valid_ff && rsp_oor_ff, (rsp_type_ff == sgrt_pkg::REQ_NONE) && rsp_last_ff, "bad flagged item")
   `SGRT_ASSERT_NEXT(a_scan_start, accept && (req.cmd == sgrt_pkg::CMD_CONNECT) && (count_ff != '0), (state_ff == sgrt_pkg::ST_SCAN) && !pend_valid_ff, "scan did not start")

endmodule
